// File: design/swbl_pkg.sv
// ----------------------------------------------------------------------------
// swbl_pkg
// Shared constants and types for the subtract-with-borrow luxury generator.
// ----------------------------------------------------------------------------
`default_nettype none

package swbl_pkg;

    // Lags of the recurrence
    localparam int LONG_LAG  = 43;
    localparam int SHORT_LAG = 22;

    // Widths
    localparam int WORD_W  = 32;
    localparam int ADDR_W  = $clog2(LONG_LAG);
    localparam int POS_W   = $clog2(LONG_LAG + 1);
    localparam int LUX_W   = 3;
    localparam int LUX_MAX = (1 << LUX_W) - 1;
    localparam int DISC_W  = $clog2(LONG_LAG * LUX_MAX + 1);
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam int REG_IDX_W = PADDR_W - 2;

    // Modulus correction: adding 2^32-5 modulo 2^32
    localparam logic [WORD_W-1:0] MOD_ADD = 32'hFFFF_FFFB;

    // Zero-based lag slot indexes after reset or load
    localparam logic [ADDR_W-1:0] LONG_START  = ADDR_W'(LONG_LAG - 1);
    localparam logic [ADDR_W-1:0] SHORT_START = ADDR_W'((SHORT_LAG - 1) % LONG_LAG);
    localparam logic [ADDR_W-1:0] LAST_SLOT   = ADDR_W'(LONG_LAG - 1);
    localparam logic [ADDR_W-1:0] SLOT_ONE    = ADDR_W'(0);
    localparam logic [ADDR_W-1:0] SLOT_TWO    = ADDR_W'(1);
    localparam logic [POS_W-1:0]  BLOCK_LEN   = POS_W'(LONG_LAG);

    // Configuration
    localparam logic [LUX_W-1:0]     LUX_RESET   = LUX_W'(1);
    localparam logic [REG_IDX_W-1:0] REG_LUXURY  = REG_IDX_W'(0);

    // Input opcodes
    localparam logic OP_GENERATE = 1'b0;
    localparam logic OP_LOAD     = 1'b1;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_READ = 3'b010,
        ST_CALC = 3'b100
    } state_t;

    // Result of one recurrence step
    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic              borrow;
    } step_result_t;

endpackage

`default_nettype wire

// File: design/subtract_with_borrow_luxury_prng_unit.sv
// ----------------------------------------------------------------------------
// subtract_with_borrow_luxury_prng_unit
// Lagged subtract-with-borrow generator (lags 43/22, mod 2^32-5) with luxury
// discarding; lag words live in a dual-read RAM.
// ----------------------------------------------------------------------------
//   channel  direction  handshake        payload
//   s_       in         s_valid/s_ready  s_opcode, s_seed_word
//   m_       out        m_valid/m_ready  m_random_word
//   apb      in/out     psel/penable     paddr, pwdata, prdata (luxury_level)
//
// A load item writes the seed to the RAM at acceptance; the sequencer stays
// idle. Each recurrence step is the RAM read of both lag words (ST_READ),
// then the subtract and write-back (ST_CALC). A generate item runs one step
// and returns its word; on the last item of each block of 43 outputs it first
// runs 43 * luxury_level discarded steps. No new item is taken until the
// sequencer is back in ST_IDLE, so generate items do not overlap.
// A result waits in the output register; a new item is taken meanwhile, and
// the final step stalls only while that register is full and m_ready is low.
// Reset is synchronous; the RAM contents are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module subtract_with_borrow_luxury_prng_unit (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [swbl_pkg::PADDR_W-1:0] paddr,
    input  wire logic [swbl_pkg::PDATA_W-1:0] pwdata,
    output logic      [swbl_pkg::PDATA_W-1:0] prdata,
    output logic                              pready,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic                         s_opcode,
    input  wire logic [swbl_pkg::WORD_W-1:0]  s_seed_word,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic      [swbl_pkg::WORD_W-1:0]  m_random_word
);

    swbl_pkg::state_t              state_reg, state_next;
    logic [swbl_pkg::ADDR_W-1:0]   long_reg, long_next;
    logic [swbl_pkg::ADDR_W-1:0]   short_reg, short_next;
    logic [swbl_pkg::ADDR_W-1:0]   slot_reg, slot_next;
    logic [swbl_pkg::POS_W-1:0]    pos_reg, pos_next;
    logic [swbl_pkg::DISC_W-1:0]   remain_reg, remain_next;
    logic                          borrow_reg, borrow_next;
    logic                          m_valid_reg, m_valid_next;
    logic [swbl_pkg::WORD_W-1:0]   m_data_reg, m_data_next;

    logic [swbl_pkg::LUX_W-1:0]    luxury;
    logic [swbl_pkg::WORD_W-1:0]   short_word, long_word;
    swbl_pkg::step_result_t        step;
    logic                          in_fire, load_fire, gen_fire;
    logic                          out_free, calc_go, final_go;
    logic [swbl_pkg::POS_W-1:0]    pos_inc;
    logic [swbl_pkg::WORD_W-1:0]   seed_fixed;
    logic                          ram_we;
    logic [swbl_pkg::ADDR_W-1:0]   ram_waddr;
    logic [swbl_pkg::WORD_W-1:0]   ram_wdata;

    swbl_apb u_apb (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .luxury  (luxury)
    );

    swbl_ram #(
        .WIDTH (swbl_pkg::WORD_W),
        .DEPTH (swbl_pkg::LONG_LAG)
    ) u_ram (
        .clk       (aclk),
        .wr_en     (ram_we),
        .wr_addr   (ram_waddr),
        .wr_data   (ram_wdata),
        .rd_addr_a (short_reg),
        .rd_data_a (short_word),
        .rd_addr_b (long_reg),
        .rd_data_b (long_word)
    );

    swbl_step u_step (
        .short_word (short_word),
        .long_word  (long_word),
        .borrow_in  (borrow_reg),
        .result     (step)
    );

    // Handshake decode
    assign s_ready   = (state_reg == swbl_pkg::ST_IDLE);
    assign in_fire   = s_valid && s_ready;
    assign load_fire = in_fire && (s_opcode == swbl_pkg::OP_LOAD);
    assign gen_fire  = in_fire && (s_opcode == swbl_pkg::OP_GENERATE);
    assign out_free  = !m_valid_reg || m_ready;
    assign calc_go   = (state_reg == swbl_pkg::ST_CALC)
                       && ((remain_reg != '0) || out_free);
    assign final_go  = calc_go && (remain_reg == '0);
    assign pos_inc   = pos_reg + swbl_pkg::POS_W'(1);

    assign m_valid       = m_valid_reg;
    assign m_random_word = m_data_reg;

    // Force the low bit of the first two seed slots
    always_comb begin
        seed_fixed = s_seed_word;
        if (slot_reg == swbl_pkg::SLOT_ONE) begin
            seed_fixed[0] = 1'b1;
        end else if (slot_reg == swbl_pkg::SLOT_TWO) begin
            seed_fixed[0] = 1'b0;
        end
    end

    // RAM write: seed on load, new word on each step
    assign ram_we    = load_fire || calc_go;
    assign ram_waddr = load_fire ? slot_reg : long_reg;
    assign ram_wdata = load_fire ? seed_fixed : step.word;

    // Sequencer and pointer updates
    always_comb begin
        state_next   = state_reg;
        long_next    = long_reg;
        short_next   = short_reg;
        slot_next    = slot_reg;
        pos_next     = pos_reg;
        remain_next  = remain_reg;
        borrow_next  = borrow_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;

        if (m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            swbl_pkg::ST_IDLE: begin
                if (load_fire) begin
                    slot_next   = (slot_reg == swbl_pkg::LAST_SLOT)
                                  ? '0 : slot_reg + swbl_pkg::ADDR_W'(1);
                    borrow_next = 1'b1;
                    long_next   = swbl_pkg::LONG_START;
                    short_next  = swbl_pkg::SHORT_START;
                    pos_next    = '0;
                end else if (gen_fire) begin
                    state_next = swbl_pkg::ST_READ;
                    if (pos_inc >= swbl_pkg::BLOCK_LEN) begin
                        pos_next    = '0;
                        remain_next = swbl_pkg::DISC_W'(swbl_pkg::LONG_LAG)
                                      * swbl_pkg::DISC_W'(luxury);
                    end else begin
                        pos_next    = pos_inc;
                        remain_next = '0;
                    end
                end
            end
            swbl_pkg::ST_READ: begin
                state_next = swbl_pkg::ST_CALC;
            end
            swbl_pkg::ST_CALC: begin
                if (calc_go) begin
                    borrow_next = step.borrow;
                    long_next   = (long_reg == '0)
                                  ? swbl_pkg::LAST_SLOT : long_reg - swbl_pkg::ADDR_W'(1);
                    short_next  = (short_reg == '0)
                                  ? swbl_pkg::LAST_SLOT : short_reg - swbl_pkg::ADDR_W'(1);
                    if (final_go) begin
                        m_valid_next = 1'b1;
                        m_data_next  = step.word;
                        state_next   = swbl_pkg::ST_IDLE;
                    end else begin
                        remain_next = remain_reg - swbl_pkg::DISC_W'(1);
                        state_next  = swbl_pkg::ST_READ;
                    end
                end
            end
            default: begin
                state_next = swbl_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= swbl_pkg::ST_IDLE;
            long_reg    <= swbl_pkg::LONG_START;
            short_reg   <= swbl_pkg::SHORT_START;
            slot_reg    <= '0;
            pos_reg     <= '0;
            remain_reg  <= '0;
            borrow_reg  <= 1'b1;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            long_reg    <= long_next;
            short_reg   <= short_next;
            slot_reg    <= slot_next;
            pos_reg     <= pos_next;
            remain_reg  <= remain_next;
            borrow_reg  <= borrow_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Output payload
    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

endmodule

`default_nettype wire

// File: design/swbl_ram.sv
// ----------------------------------------------------------------------------
// swbl_ram
// Generic RAM: one write port, two registered read ports.
// ----------------------------------------------------------------------------
`default_nettype none

module swbl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 43
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr_a,
    output logic      [WIDTH-1:0]         rd_data_a,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr_b,
    output logic      [WIDTH-1:0]         rd_data_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered reads
    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_a <= mem[rd_addr_a];
        rd_data_b <= mem[rd_addr_b];
    end

endmodule

`default_nettype wire

// File: design/swbl_step.sv
// ----------------------------------------------------------------------------
// swbl_step
// One subtract-with-borrow step: short minus long minus borrow, mod 2^32-5.
// ----------------------------------------------------------------------------
`default_nettype none

module swbl_step (
    input  wire logic [swbl_pkg::WORD_W-1:0] short_word,
    input  wire logic [swbl_pkg::WORD_W-1:0] long_word,
    input  wire logic                        borrow_in,
    output swbl_pkg::step_result_t           result
);

    logic [swbl_pkg::WORD_W:0] diff;

    // Sign of the wide difference is the new borrow
    assign diff = {1'b0, short_word} - {1'b0, long_word}
                  - {{swbl_pkg::WORD_W{1'b0}}, borrow_in};

    always_comb begin
        result.borrow = diff[swbl_pkg::WORD_W];
        if (diff[swbl_pkg::WORD_W]) begin
            result.word = diff[swbl_pkg::WORD_W-1:0] + swbl_pkg::MOD_ADD;
        end else begin
            result.word = diff[swbl_pkg::WORD_W-1:0];
        end
    end

endmodule

`default_nettype wire

// File: design/swbl_apb.sv
// ----------------------------------------------------------------------------
// swbl_apb
// APB register slave holding the luxury level.
// ----------------------------------------------------------------------------
`default_nettype none

module swbl_apb (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [swbl_pkg::PADDR_W-1:0] paddr,
    input  wire logic [swbl_pkg::PDATA_W-1:0] pwdata,
    output logic      [swbl_pkg::PDATA_W-1:0] prdata,
    output logic                              pready,
    output logic      [swbl_pkg::LUX_W-1:0]   luxury
);

    logic [swbl_pkg::LUX_W-1:0]     luxury_reg;
    logic [swbl_pkg::REG_IDX_W-1:0] reg_idx;
    logic                           wr_fire;

    assign pready  = 1'b1;
    assign reg_idx = paddr[swbl_pkg::PADDR_W-1:2];
    assign wr_fire = psel && penable && pwrite && (reg_idx == swbl_pkg::REG_LUXURY);
    assign luxury  = luxury_reg;

    // Hold the luxury level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            luxury_reg <= swbl_pkg::LUX_RESET;
        end else if (wr_fire) begin
            luxury_reg <= pwdata[swbl_pkg::LUX_W-1:0];
        end
    end

    // Read back
    always_comb begin
        prdata = '0;
        if (reg_idx == swbl_pkg::REG_LUXURY) begin
            prdata = {{(swbl_pkg::PDATA_W - swbl_pkg::LUX_W){1'b0}}, luxury_reg};
        end
    end

endmodule

`default_nettype wire

// File: design/swbl_checker.sv
// ----------------------------------------------------------------------------
// swbl_checker
// Port-level checks for the generator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module swbl_checker (
    input wire logic                        aclk,
    input wire logic                        aresetn,
    input wire logic                        pready,
    input wire logic                        s_valid,
    input wire logic                        s_ready,
    input wire logic                        s_opcode,
    input wire logic                        m_valid,
    input wire logic                        m_ready,
    input wire logic [swbl_pkg::WORD_W-1:0] m_random_word
);

    // No result is pending right after reset
    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // A generate item occupies the step unit, so s_ready falls once it is accepted
    a_gen_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && (s_opcode == swbl_pkg::OP_GENERATE)) |=> !s_ready)
        else $error("item accepted right after a generate item");

    // A load item never produces a result
    a_load_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && (s_opcode == swbl_pkg::OP_LOAD) && !m_valid) |=> !m_valid)
        else $error("result appeared after a load item");

    // A stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_random_word)))
        else $error("stalled result changed");

    // Register port never waits
    a_pready: assert property (@(posedge aclk) disable iff (!aresetn) pready)
        else $error("pready low");

endmodule

bind subtract_with_borrow_luxury_prng_unit swbl_checker u_swbl_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .pready        (pready),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .s_opcode      (s_opcode),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_random_word (m_random_word)
);

`default_nettype wire
